>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/lcdni_pkg.sv
// ----------------------------------------------------------------------------
// lcdni_pkg
// types, codes and the power-up transfer table of the lcd nibble sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdni_pkg;

   typedef enum logic [2:0] {
      CMD_INIT  = 3'd0,
      CMD_CHAR  = 3'd1,
      CMD_GOTO  = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_RAW   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NOT_INIT     = 2'd1,
      ST_ALREADY_INIT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WAIT_NONE  = 2'd0,
      WAIT_150US = 2'd1,
      WAIT_5MS   = 2'd2,
      WAIT_150MS = 2'd3
   } wait_type;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_PAIR,
      JOB_SINGLE,
      JOB_REFUSE
   } job_kind_type;

   localparam logic [7:0] ROW1_BASE       = 8'h80;
   localparam logic [7:0] ROW2_BASE       = 8'hC0;
   localparam logic [7:0] CLEAR_CODE      = 8'h01;
   localparam logic [3:0] INIT_LAST_STEP  = 4'd12;

   localparam logic [3:0] INIT_NIBBLES [0:11] = '{
      4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h6, 4'h0, 4'h1
   };

   typedef struct packed {
      job_kind_type kind;
      logic         reg_select;
      logic [7:0]   data;
      status_type   status;
   } job_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       bus_write;
      logic       strobe_res;
      wait_type   extra_wait;
      status_type status;
      logic       last;
   } xfer_type;

   // job queue head as presented to the back: valid flag and job
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_head_type;

   function automatic xfer_type init_xfer(input logic [3:0] step);
      xfer_type x;
      x            = '0;
      x.bus_write  = 1'b1;
      x.status     = ST_OK;
      x.extra_wait = WAIT_NONE;
      if (step == 4'd0) begin
         x.extra_wait = WAIT_150MS;
      end else begin
         x.strobe_res = 1'b1;
         x.nibble     = INIT_NIBBLES[step - 4'd1];
         if (step == 4'd1) begin
            x.extra_wait = WAIT_5MS;
         end else if (step == 4'd2) begin
            x.extra_wait = WAIT_150US;
         end
      end
      x.last = (step == INIT_LAST_STEP);
      return x;
   endfunction

endpackage

>>> hw/rtl/lcdni_front.sv
// ----------------------------------------------------------------------------
// lcdni_front
// maps each accepted command to at most one job and tracks the init flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdni_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        command,
   input  logic [7:0]        char_code,
   input  logic [1:0]        row,
   input  logic [7:0]        column,
   input  logic [3:0]        raw_nibble,
   output logic              job_push,
   output lcdni_pkg::job_type job
);
   import lcdni_pkg::*;

   logic       initialized_ff;
   logic       initialized_in;
   logic [7:0] base;

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff <= 1'b0;
      end else begin
         initialized_ff <= initialized_in;
      end
   end

   always_comb begin
      initialized_in = initialized_ff;
      job_push       = 1'b0;
      job            = '0;
      job.kind       = JOB_REFUSE;
      job.status     = ST_OK;
      base           = (row == 2'd1) ? ROW1_BASE : ROW2_BASE;
      if (accept) begin
         unique case (command_type'(command))
            CMD_INIT: begin
               job_push = 1'b1;
               if (initialized_ff) begin
                  job.status = ST_ALREADY_INIT;
               end else begin
                  job.kind       = JOB_INIT;
                  initialized_in = 1'b1;
               end
            end
            CMD_CHAR, CMD_GOTO, CMD_CLEAR: begin
               if (!initialized_ff) begin
                  job_push   = 1'b1;
                  job.status = ST_NOT_INIT;
               end else if (command_type'(command) == CMD_CHAR) begin
                  job_push       = 1'b1;
                  job.kind       = JOB_PAIR;
                  job.reg_select = 1'b1;
                  job.data       = char_code;
               end else if (command_type'(command) == CMD_CLEAR) begin
                  job_push = 1'b1;
                  job.kind = JOB_PAIR;
                  job.data = CLEAR_CODE;
               end else if (row == 2'd1 || row == 2'd2) begin
                  job_push = 1'b1;
                  job.kind = JOB_PAIR;
                  job.data = base + column - 8'd1;
               end
            end
            CMD_RAW: begin
               job_push = 1'b1;
               job.kind = JOB_SINGLE;
               job.data = {4'h0, raw_nibble};
            end
            default: begin
               job_push = 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/lcdni_job_queue.sv
// ----------------------------------------------------------------------------
// lcdni_job_queue
// two-entry job queue between the front and the transfer sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdni_job_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcdni_pkg::job_type     push_job,
   input  logic                   pop,
   output logic                   full,
   output lcdni_pkg::job_head_type head
);
   import lcdni_pkg::*;

   job_type    entry_ff [0:1];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      full       = (count_ff == 2'd2);
      head.valid = (count_ff != 2'd0);
      head.job   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

endmodule

>>> hw/rtl/lcdni_back.sv
// ----------------------------------------------------------------------------
// lcdni_back
// expands the head job into transfers, one per cycle while out_full is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdni_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdni_pkg::job_head_type head,
   input  logic                    out_full,
   output logic                    job_pop,
   output logic                    xfer_push,
   output lcdni_pkg::xfer_type     xfer
);
   import lcdni_pkg::*;

   logic [3:0] step_ff;
   logic [3:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 4'd0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      xfer            = '0;
      xfer.bus_write  = 1'b1;
      xfer.strobe_res = 1'b1;
      xfer.extra_wait = WAIT_NONE;
      xfer.status     = ST_OK;
      xfer.reg_select = head.job.reg_select;
      unique case (head.job.kind)
         JOB_INIT: begin
            xfer = init_xfer(step_ff);
         end
         JOB_PAIR: begin
            xfer.nibble = (step_ff == 4'd0) ? head.job.data[7:4] : head.job.data[3:0];
            xfer.last   = (step_ff != 4'd0);
         end
         JOB_SINGLE: begin
            xfer.nibble = head.job.data[3:0];
            xfer.last   = 1'b1;
         end
         JOB_REFUSE: begin
            xfer        = '0;
            xfer.status = head.job.status;
            xfer.last   = 1'b1;
         end
         default: begin
            xfer.last = 1'b1;
         end
      endcase

      xfer_push = head.valid && !out_full;
      job_pop   = xfer_push && xfer.last;
      step_in   = step_ff;
      if (xfer_push) begin
         step_in = xfer.last ? 4'd0 : step_ff + 4'd1;
      end
   end

endmodule

>>> hw/rtl/lcdni_out_queue.sv
// ----------------------------------------------------------------------------
// lcdni_out_queue
// two-entry result queue that drives the response side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdni_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdni_pkg::xfer_type push_xfer,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output lcdni_pkg::xfer_type head
);
   import lcdni_pkg::*;

   xfer_type   entry_ff [0:1];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_xfer;
      end
   end

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head      = entry_ff[rd_ptr_ff];
      do_pop    = pop && !empty;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

endmodule

>>> hw/rtl/lcd_nibble_interface_sequencer_top.sv
// ----------------------------------------------------------------------------
// lcd_nibble_interface_sequencer_top
// 4-bit character lcd bus sequencer: one command in, a run of nibble
// transfers out
//
// request side: a queue input; an item is taken on a clock edge with
//    req_push high and req_full low
// response side: a queue output; the oldest transfer sits on rsp_* while
//    rsp_empty is low and leaves on an edge with rsp_pop high
// a command yields 0 to 13 transfers, the final one flagged by rsp_last;
//    refused commands yield one status transfer, a goto to an invalid row
//    or an undefined command yields none
// order: a taken item is registered in the job queue, and each of its
//    transfers in turn in the response queue
// throughput: one transfer per cycle while the response queue is not full;
//    an item has 13 transfers for initialize, 2 for character, goto, clear,
//    1 for raw or a refusal; set by the single-step transfer sequencer
// a two-entry job queue and a two-entry response queue decouple the sides;
//    when the receiver stalls, the response queue fills, the sequencer
//    holds, then the job queue fills and req_full rises
// reset clears both queues, the sequencer step and the initialized flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd_nibble_interface_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_command,
   input  logic [7:0] req_char_code,
   input  logic [1:0] req_row,
   input  logic [7:0] req_column,
   input  logic [3:0] req_raw_nibble,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_reg_select,
   output logic [3:0] rsp_nibble,
   output logic       rsp_bus_write,
   output logic       rsp_strobe_res,
   output logic [1:0] rsp_extra_wait,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);
   import lcdni_pkg::*;

   logic         accept;
   logic         job_push;
   job_type      job;
   job_head_type head;
   logic         job_pop;
   logic         xfer_push;
   xfer_type     xfer;
   logic         out_full;
   xfer_type     rsp_head;

   assign accept = req_push && !req_full;

   lcdni_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .char_code  (req_char_code),
      .row        (req_row),
      .column     (req_column),
      .raw_nibble (req_raw_nibble),
      .job_push   (job_push),
      .job        (job)
   );

   lcdni_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (job_pop),
      .full     (req_full),
      .head     (head)
   );

   lcdni_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .out_full  (out_full),
      .job_pop   (job_pop),
      .xfer_push (xfer_push),
      .xfer      (xfer)
   );

   lcdni_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (xfer_push),
      .push_xfer (xfer),
      .pop       (rsp_pop),
      .full      (out_full),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_reg_select = rsp_head.reg_select;
   assign rsp_nibble     = rsp_head.nibble;
   assign rsp_bus_write  = rsp_head.bus_write;
   assign rsp_strobe_res = rsp_head.strobe_res;
   assign rsp_extra_wait = rsp_head.extra_wait;
   assign rsp_status     = rsp_head.status;
   assign rsp_last       = rsp_head.last;

   `ASSERT_IMP(a_no_push_when_full, clock, reset, xfer_push, !out_full)
   `ASSERT_IMP(a_pop_only_on_last, clock, reset, job_pop, xfer_push && xfer.last)
   `ASSERT_IMP(a_refusal_is_single, clock, reset, xfer_push && (xfer.status != ST_OK), xfer.last && !xfer.bus_write)
   `ASSERT_NEXT(a_job_reaches_back, clock, reset, job_push, head.valid)

endmodule
